@@ hw/rtl/bgs_pkg.sv @@
// bgs_pkg: request and response types, register indexes and fixed-point helpers
// for the bilinear grid sampler; no dependencies
package bgs_pkg;

  localparam int OP_W   = 40;
  localparam int PROD_W = 71;
  localparam int CFG_W  = 31;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOUNDARY    = 3'd2;
  localparam logic [IDX_W-1:0] REG_CELL_W      = 3'd3;
  localparam logic [IDX_W-1:0] REG_CELL_H      = 3'd4;
  localparam logic [IDX_W-1:0] REG_INV_CELL_W  = 3'd5;
  localparam logic [IDX_W-1:0] REG_INV_CELL_H  = 3'd6;

  localparam logic [16:0] W_ONE = 17'h10000;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_GRAD   = 2'd2,
    KIND_CURL   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic signed [31:0] cell_value;
  } bgs_req_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               out_of_range;
  } bgs_rsp_t;

  function automatic logic signed [PROD_W-1:0] round16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + PROD_W'(32768);
    return s >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sh7FFFFFFF);
    lo = -PROD_W'(64'sh80000000);
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return 32'(v);
  endfunction

endpackage

@@ hw/rtl/bgs_mul.sv @@
// bgs_mul: shared signed-by-unsigned multiplier, two partial products computed in turn
// depends on bgs_pkg
module bgs_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [bgs_pkg::OP_W-1:0]   a_i,
  input  logic [bgs_pkg::CFG_W-1:0]         b_i,
  output logic                              done_o,
  output logic signed [bgs_pkg::PROD_W-1:0] p_o
);
  import bgs_pkg::*;

  localparam int LO_W = 20;
  localparam int HI_W = OP_W - LO_W;

  logic [1:0]                     phase_q;
  logic                           done_q;
  logic signed [OP_W-1:0]         a_q;
  logic [CFG_W-1:0]               b_q;
  logic [LO_W+CFG_W-1:0]          lo_q;
  logic signed [HI_W+CFG_W:0]     hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        2'd0: if (start_i) phase_q <= 2'd1;
        2'd1: phase_q <= 2'd2;
        2'd2: begin
          phase_q <= 2'd0;
          done_q  <= 1'b1;
        end
        default: phase_q <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == 2'd0 && start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (phase_q == 2'd1) lo_q <= a_q[LO_W-1:0] * b_q;
    if (phase_q == 2'd2) hi_q <= $signed(a_q[OP_W-1:LO_W]) * $signed({1'b0, b_q});
  end

  assign done_o = done_q;
  assign p_o    = (PROD_W'(hi_q) <<< LO_W) + $signed(PROD_W'(lo_q));

endmodule

@@ hw/rtl/bgs_mod.sv @@
// bgs_mod: restoring remainder unit, one dividend bit a cycle
// depends on bgs_pkg
module bgs_mod #(
  parameter int NW = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [bgs_pkg::OP_W-1:0] dividend_i,
  input  logic [NW-1:0]           divisor_i,
  output logic                    done_o,
  output logic [NW-1:0]           rem_o
);
  import bgs_pkg::*;

  localparam int CW = $clog2(OP_W);

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [OP_W-1:0] dvd_q;
  logic [NW-1:0]   n_q;
  logic [NW-1:0]   rem_q;
  logic [NW:0]     trial;
  logic [NW:0]     diff;

  assign trial = {rem_q, dvd_q[OP_W-1]};
  assign diff  = trial - {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(OP_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      dvd_q <= dividend_i;
      n_q   <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[OP_W-2:0], 1'b0};
      rem_q <= (trial >= {1'b0, n_q}) ? diff[NW-1:0] : trial[NW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/bgs_grid_ram.sv @@
// bgs_grid_ram: grid cell store, one write and one registered read port
// no dependencies
module bgs_grid_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic signed [31:0] rdata_o
);
  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/bilinear_grid_sampler_core.sv @@
// bilinear_grid_sampler_core: top level, configuration registers and sequencer
// depends on bgs_pkg, bgs_mul, bgs_mod, bgs_grid_ram
// An in-grid cell write is stored as accepted. A sample, gradient or curl is worked
// through one shared multiplier and one bit-serial remainder unit under a
// sequencer, and the request port stays low until the result is handed to the
// response register. Per in-range sample, each axis is resolved on the multiplier
// in clamp mode, and also through the 40-step remainder loop with wrap; then the
// four cells are read from the single read port and three interpolations are made;
// a gradient or curl takes four such samples and then scales. An out-of-range
// sample skips this work. No clearing pass is made.
module bilinear_grid_sampler_core #(
  parameter int MAX_GRID_X = 64,
  parameter int MAX_GRID_Y = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  bgs_pkg::bgs_req_t         req_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output bgs_pkg::bgs_rsp_t         rsp_o,
  input  logic                      cfg_we_i,
  input  logic [bgs_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [bgs_pkg::CFG_W-1:0] cfg_data_i
);
  import bgs_pkg::*;

  localparam int MAXN  = (MAX_GRID_X > MAX_GRID_Y) ? MAX_GRID_X : MAX_GRID_Y;
  localparam int NW    = $clog2(MAXN + 1);
  localparam int DEPTH = MAX_GRID_X * MAX_GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = NW + CFG_W;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CHECK   = 4'd1;
  localparam logic [3:0] ST_AXMUL   = 4'd2;
  localparam logic [3:0] ST_AXWAIT  = 4'd3;
  localparam logic [3:0] ST_MODWAIT = 4'd4;
  localparam logic [3:0] ST_RD      = 4'd5;
  localparam logic [3:0] ST_LMUL    = 4'd6;
  localparam logic [3:0] ST_LWAIT   = 4'd7;
  localparam logic [3:0] ST_NEXT    = 4'd8;
  localparam logic [3:0] ST_SMUL    = 4'd9;
  localparam logic [3:0] ST_SWAIT   = 4'd10;
  localparam logic [3:0] ST_OUT     = 4'd11;

  // configuration
  logic [6:0]       gw_q, gh_q;
  logic [1:0]       bmode_q;
  logic [CFG_W-1:0] cw_q, ch_q, icw_q, ich_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= 7'd64;
      gh_q    <= 7'd64;
      bmode_q <= 2'd0;
      cw_q    <= CFG_W'(65536);
      ch_q    <= CFG_W'(65536);
      icw_q   <= CFG_W'(65536);
      ich_q   <= CFG_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  gw_q    <= cfg_data_i[6:0];
        REG_GRID_HEIGHT: gh_q    <= cfg_data_i[6:0];
        REG_BOUNDARY:    bmode_q <= cfg_data_i[1:0];
        REG_CELL_W:      cw_q    <= cfg_data_i;
        REG_CELL_H:      ch_q    <= cfg_data_i;
        REG_INV_CELL_W:  icw_q   <= cfg_data_i;
        REG_INV_CELL_H:  ich_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [NW-1:0]    nx, ny;
  logic [CFG_W-1:0] cw_e, ch_e, icw_e, ich_e;
  logic [LW-1:0]    lim_x_q, lim_y_q;

  always_comb begin
    if (gw_q < 7'd2) nx = NW'(2);
    else if (32'(gw_q) > MAX_GRID_X) nx = NW'(MAX_GRID_X);
    else nx = NW'(gw_q);
    if (gh_q < 7'd2) ny = NW'(2);
    else if (32'(gh_q) > MAX_GRID_Y) ny = NW'(MAX_GRID_Y);
    else ny = NW'(gh_q);
  end

  assign cw_e  = (cw_q  == '0) ? CFG_W'(1) : cw_q;
  assign ch_e  = (ch_q  == '0) ? CFG_W'(1) : ch_q;
  assign icw_e = (icw_q == '0) ? CFG_W'(1) : icw_q;
  assign ich_e = (ich_q == '0) ? CFG_W'(1) : ich_q;

  // domain limits follow the configuration, which the user must keep stable while busy; the block does not enforce it
  always_ff @(posedge clk_i) begin
    lim_x_q <= LW'(nx) * LW'(cw_e);
    lim_y_q <= LW'(ny) * LW'(ch_e);
  end

  // sequencer state
  logic [3:0]          state_q, state_d;
  bgs_req_t            req_q;
  logic [1:0]          k_q;
  logic                axis_q;
  logic [1:0]          lstep_q;
  logic                sstep_q;
  logic [2:0]          cnt_q;
  logic                oor_q;
  logic                neg_q;
  logic [NW-1:0]       xl_q, xr_q, yb_q, yt_q;
  logic [16:0]         wx_q, wy_q;
  logic signed [31:0]  cell_q [4];
  logic signed [33:0]  samp_q [4];
  logic signed [33:0]  bot_q, top_q;
  logic signed [31:0]  rx_q, ry_q;
  logic                rsp_valid_q;
  bgs_rsp_t            rsp_q;

  // sample position
  logic signed [32:0] px, py, hx, hy, pos_x_k, pos_y_k;
  assign px = 33'(req_q.pos_x);
  assign py = 33'(req_q.pos_y);
  assign hx = $signed({3'b000, cw_e[CFG_W-1:1]});
  assign hy = $signed({3'b000, ch_e[CFG_W-1:1]});

  always_comb begin
    pos_x_k = px;
    pos_y_k = py;
    if (req_q.kind != KIND_SAMPLE) begin
      case (k_q)
        2'd0:    pos_x_k = px - hx;
        2'd1:    pos_x_k = px + hx;
        2'd2:    pos_y_k = py + hy;
        default: pos_y_k = py - hy;
      endcase
    end
  end

  logic in_domain;
  assign in_domain = !pos_x_k[32] && (LW'(pos_x_k[31:0]) < lim_x_q) &&
                     !pos_y_k[32] && (LW'(pos_y_k[31:0]) < lim_y_q);

  // axis selection
  logic signed [32:0] pos_sel;
  logic [CFG_W-2:0]   hc_sel;
  logic [CFG_W-1:0]   inv_sel;
  logic [NW-1:0]      n_sel;
  logic               wrap_sel;

  assign pos_sel  = axis_q ? pos_y_k : pos_x_k;
  assign hc_sel   = axis_q ? ch_e[CFG_W-1:1] : cw_e[CFG_W-1:1];
  assign inv_sel  = axis_q ? ich_e : icw_e;
  assign n_sel    = axis_q ? ny : nx;
  assign wrap_sel = axis_q ? bmode_q[1] : bmode_q[0];

  // shared multiplier
  logic                     mul_start, mul_done;
  logic signed [OP_W-1:0]   mul_a;
  logic [CFG_W-1:0]         mul_b;
  logic signed [PROD_W-1:0] mul_p, mul_r;

  assign mul_start = (state_q == ST_AXMUL) || (state_q == ST_LMUL) || (state_q == ST_SMUL);
  assign mul_r     = round16(mul_p);

  always_comb begin
    mul_a = OP_W'(pos_sel) - $signed({{(OP_W-CFG_W+1){1'b0}}, hc_sel});
    mul_b = inv_sel;
    if (state_q == ST_LMUL) begin
      case (lstep_q)
        2'd0:    mul_a = OP_W'(cell_q[1]) - OP_W'(cell_q[0]);
        2'd1:    mul_a = OP_W'(cell_q[3]) - OP_W'(cell_q[2]);
        default: mul_a = OP_W'(top_q) - OP_W'(bot_q);
      endcase
      mul_b = (lstep_q == 2'd2) ? CFG_W'(wy_q) : CFG_W'(wx_q);
    end else if (state_q == ST_SMUL) begin
      if (req_q.kind == KIND_GRAD) begin
        mul_a = sstep_q ? OP_W'(samp_q[2]) - OP_W'(samp_q[3])
                        : OP_W'(samp_q[1]) - OP_W'(samp_q[0]);
      end else begin
        mul_a = sstep_q ? OP_W'(samp_q[0]) - OP_W'(samp_q[1])
                        : OP_W'(samp_q[2]) - OP_W'(samp_q[3]);
      end
      mul_b = sstep_q ? ich_e : icw_e;
    end
  end

  bgs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // index resolution
  logic signed [OP_W-1:0] i_val, n_m1;
  logic [OP_W-1:0]        i_mag;
  logic                   i_neg;
  logic [16:0]            frac;
  logic                   mod_start, mod_done;
  logic [NW-1:0]          mod_rem, m_val, m_next;

  assign i_val = OP_W'($signed(mul_p[PROD_W-1:32]));
  assign i_neg = i_val[OP_W-1];
  assign i_mag = i_neg ? OP_W'(-i_val) : OP_W'(i_val);
  assign frac  = {1'b0, mul_p[31:16]};
  assign n_m1  = $signed(OP_W'(n_sel)) - OP_W'(1);

  assign mod_start = (state_q == ST_AXWAIT) && mul_done && wrap_sel;
  assign m_val     = (neg_q && mod_rem != '0) ? n_sel - mod_rem : mod_rem;
  assign m_next    = (m_val == n_sel - NW'(1)) ? '0 : m_val + NW'(1);

  bgs_mod #(.NW(NW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (i_mag),
    .divisor_i  (n_sel),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // grid store
  logic               req_acc, wr_en;
  logic [AW-1:0]      waddr, raddr;
  logic [NW-1:0]      rd_x, rd_y;
  logic signed [31:0] rdata;

  assign req_ready_o = (state_q == ST_IDLE);
  assign req_acc     = req_valid_i && req_ready_o;
  assign wr_en       = req_acc && (req_i.kind == KIND_WRITE) &&
                       (OP_W'(req_i.cell_x) < OP_W'(nx)) && (OP_W'(req_i.cell_y) < OP_W'(ny));
  assign waddr = AW'((2*NW+6)'(req_i.cell_x) * (2*NW+6)'(ny) + (2*NW+6)'(req_i.cell_y));
  assign rd_x  = cnt_q[0] ? xr_q : xl_q;
  assign rd_y  = cnt_q[1] ? yt_q : yb_q;
  assign raddr = AW'((2*NW)'(rd_x) * (2*NW)'(ny) + (2*NW)'(rd_y));

  bgs_grid_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (req_i.cell_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // next state
  logic out_free;
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (req_acc && req_i.kind != KIND_WRITE) state_d = ST_CHECK;
      ST_CHECK:   state_d = in_domain ? ST_AXMUL : ST_NEXT;
      ST_AXMUL:   state_d = ST_AXWAIT;
      ST_AXWAIT: begin
        if (mul_done) begin
          if (wrap_sel) state_d = ST_MODWAIT;
          else state_d = axis_q ? ST_RD : ST_AXMUL;
        end
      end
      ST_MODWAIT: if (mod_done) state_d = axis_q ? ST_RD : ST_AXMUL;
      ST_RD:      if (cnt_q == 3'd4) state_d = ST_LMUL;
      ST_LMUL:    state_d = ST_LWAIT;
      ST_LWAIT:   if (mul_done) state_d = (lstep_q == 2'd2) ? ST_NEXT : ST_LMUL;
      ST_NEXT: begin
        if (req_q.kind == KIND_SAMPLE) state_d = ST_OUT;
        else if (k_q == 2'd3) state_d = ST_SMUL;
        else state_d = ST_CHECK;
      end
      ST_SMUL:    state_d = ST_SWAIT;
      ST_SWAIT:   if (mul_done) state_d = sstep_q ? ST_OUT : ST_SMUL;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      k_q         <= 2'd0;
      axis_q      <= 1'b0;
      lstep_q     <= 2'd0;
      sstep_q     <= 1'b0;
      cnt_q       <= 3'd0;
      oor_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) rsp_valid_q <= 1'b1;
      else if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          k_q     <= 2'd0;
          oor_q   <= 1'b0;
          sstep_q <= 1'b0;
        end
        ST_CHECK: begin
          axis_q <= 1'b0;
          if (!in_domain) oor_q <= 1'b1;
        end
        ST_AXWAIT: if (mul_done && !wrap_sel) begin
          axis_q <= 1'b1;
          cnt_q  <= 3'd0;
        end
        ST_MODWAIT: if (mod_done) begin
          axis_q <= 1'b1;
          cnt_q  <= 3'd0;
        end
        ST_RD: begin
          cnt_q   <= cnt_q + 3'd1;
          lstep_q <= 2'd0;
        end
        ST_LWAIT: if (mul_done) lstep_q <= lstep_q + 2'd1;
        ST_NEXT:  k_q <= k_q + 2'd1;
        ST_SWAIT: if (mul_done) sstep_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) req_q <= req_i;
    case (state_q)
      ST_CHECK: if (!in_domain) samp_q[k_q] <= '0;
      ST_AXWAIT: if (mul_done) begin
        neg_q <= i_neg;
        if (wrap_sel) begin
          if (axis_q) wy_q <= frac;
          else wx_q <= frac;
        end else begin
          if (i_neg) begin
            if (axis_q) begin
              yb_q <= '0; yt_q <= NW'(1); wy_q <= '0;
            end else begin
              xl_q <= '0; xr_q <= NW'(1); wx_q <= '0;
            end
          end else if (i_val >= n_m1) begin
            if (axis_q) begin
              yb_q <= n_sel - NW'(2); yt_q <= n_sel - NW'(1); wy_q <= W_ONE;
            end else begin
              xl_q <= n_sel - NW'(2); xr_q <= n_sel - NW'(1); wx_q <= W_ONE;
            end
          end else begin
            if (axis_q) begin
              yb_q <= NW'(i_val); yt_q <= NW'(i_val) + NW'(1); wy_q <= frac;
            end else begin
              xl_q <= NW'(i_val); xr_q <= NW'(i_val) + NW'(1); wx_q <= frac;
            end
          end
        end
      end
      ST_MODWAIT: if (mod_done) begin
        if (axis_q) begin
          yb_q <= m_val; yt_q <= m_next;
        end else begin
          xl_q <= m_val; xr_q <= m_next;
        end
      end
      ST_RD: if (cnt_q != 3'd0) cell_q[cnt_q[1:0] - 2'd1] <= rdata;
      ST_LWAIT: if (mul_done) begin
        case (lstep_q)
          2'd0:    bot_q <= 34'(cell_q[0]) + 34'(mul_r);
          2'd1:    top_q <= 34'(cell_q[2]) + 34'(mul_r);
          default: samp_q[k_q] <= bot_q + 34'(mul_r);
        endcase
      end
      ST_SWAIT: if (mul_done) begin
        if (sstep_q) ry_q <= sat32(mul_r);
        else rx_q <= sat32(mul_r);
      end
      ST_OUT: if (out_free) begin
        rsp_q.out_of_range <= oor_q;
        if (req_q.kind == KIND_SAMPLE) begin
          rsp_q.result_x <= sat32(PROD_W'(samp_q[0]));
          rsp_q.result_y <= '0;
        end else begin
          rsp_q.result_x <= rx_q;
          rsp_q.result_y <= ry_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
